### rtl/feuf_pkg.sv
// feuf_pkg: shared widths, request kinds and outcome codes of the friend/enemy set store
// no dependencies; imported by the top level and the testbench
`default_nettype none

package feuf_pkg;

   localparam int unsigned KIND_W         = 2;
   localparam int unsigned PERSON_W       = 13;
   localparam int unsigned OUTCOME_W      = 2;
   localparam int unsigned PEOPLE_DEFAULT = 8192;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET_FRIENDS = 2'd0,
      KIND_SET_ENEMIES = 2'd1,
      KIND_ASK_FRIENDS = 2'd2,
      KIND_ASK_ENEMIES = 2'd3
   } kind_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_SET_ACCEPTED = 2'd0,
      OUT_SET_REJECTED = 2'd1,
      OUT_QUERY_NO     = 2'd2,
      OUT_QUERY_YES    = 2'd3
   } outcome_type;

endpackage

`default_nettype wire

### rtl/friend_enemy_union_find_unit.sv
// friend_enemy_union_find_unit: top level of the friend/enemy disjoint-set store
// depends on feuf_pkg (types, codes) and feuf_ram (parent table)
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid req_ready req_kind            | in
//          | req_person_a req_person_b               |
//  result  | rsp_valid rsp_ready rsp_outcome         | out
//
// one request at a time; each of the four root walks is a start read, a find walk to
// the root, then a compression walk repointing that path, all on the single read port
// of the parent ram; then decide, two union writes for an accepted set, and hand-off
// after reset a clearing pass writes each of the 2 * PEOPLE entries with its own index
// (16384 entries at the default), with req_ready low throughout
// a finished item waits in the output register; a new item is taken meanwhile and
// only its hand-off stalls until the register is free
`default_nettype none

module friend_enemy_union_find_unit #(
   parameter int unsigned PEOPLE = feuf_pkg::PEOPLE_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [feuf_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [feuf_pkg::PERSON_W-1:0]   req_person_a,
   input  wire logic [feuf_pkg::PERSON_W-1:0]   req_person_b,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [feuf_pkg::OUTCOME_W-1:0]  rsp_outcome
);

   import feuf_pkg::*;

   // node numbering: friend node p, enemy node p + PEOPLE
   localparam int unsigned NODES  = 2 * PEOPLE;
   localparam int unsigned NODE_W = $clog2(NODES);
   localparam int unsigned CMP_W  = (NODE_W > PERSON_W) ? NODE_W : PERSON_W;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
   localparam logic [NODE_W-1:0] ENEMY_OFS = NODE_W'(PEOPLE);
   localparam logic [CMP_W-1:0]  PEOPLE_C  = CMP_W'(PEOPLE);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_START  = 9'b000000100,
      ST_FIND   = 9'b000001000,
      ST_COMP   = 9'b000010000,
      ST_DECIDE = 9'b000100000,
      ST_UNION1 = 9'b001000000,
      ST_UNION2 = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [1:0]        walk_ff, walk_in;      // 0 fa, 1 fb, 2 ea, 3 eb
   logic [NODE_W-1:0] root_ff, root_in;      // walk pointer, then found root
   logic [NODE_W-1:0] cur_ff, cur_in;        // compression pointer
   logic [NODE_W-1:0] roots_ff [4];
   logic [NODE_W-1:0] roots_in [4];
   logic [NODE_W-1:0] node_a_ff, node_a_in;
   logic [NODE_W-1:0] node_b_ff, node_b_in;
   kind_type          kind_ff, kind_in;
   outcome_type       outcome_ff, outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   outcome_type       rsp_outcome_ff, rsp_outcome_in;

   logic              ram_wr_en;
   logic [NODE_W-1:0] ram_wr_addr;
   logic [NODE_W-1:0] ram_wr_data;
   logic [NODE_W-1:0] ram_rd_addr;
   logic [NODE_W-1:0] ram_rd_data;

   logic              req_fire;
   logic              in_range;
   logic              is_set;
   logic [NODE_W-1:0] walk_node;
   logic              last_walk;
   logic              set_reject;
   logic              ask_yes;
   logic [NODE_W-1:0] fa, fb, ea, eb;

   feuf_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (CMP_W'(req_person_a) < PEOPLE_C) && (CMP_W'(req_person_b) < PEOPLE_C);
   assign is_set    = (kind_type'(req_kind) == KIND_SET_FRIENDS)
                   || (kind_type'(req_kind) == KIND_SET_ENEMIES);

   // start node of the current walk
   assign walk_node = (walk_ff[0] ? node_b_ff : node_a_ff) + (walk_ff[1] ? ENEMY_OFS : '0);
   assign last_walk = (walk_ff == 2'd3);

   assign fa = roots_ff[0];
   assign fb = roots_ff[1];
   assign ea = roots_ff[2];
   assign eb = roots_ff[3];

   // relation checks on the four roots
   always_comb begin
      set_reject = 1'b0;
      ask_yes    = 1'b0;
      case (kind_ff)
         KIND_SET_FRIENDS: set_reject = (fa == eb) || (ea == fb);
         KIND_SET_ENEMIES: set_reject = (fa == fb) || (ea == eb);
         KIND_ASK_FRIENDS: ask_yes    = (fa == fb) || (ea == eb);
         KIND_ASK_ENEMIES: ask_yes    = (fa == eb) || (fb == ea);
         default: begin
            set_reject = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      walk_in        = walk_ff;
      root_in        = root_ff;
      cur_in         = cur_ff;
      roots_in       = roots_ff;
      node_a_in      = node_a_ff;
      node_b_in      = node_b_ff;
      kind_in        = kind_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = cur_ff;
      ram_wr_data    = root_ff;
      ram_rd_addr    = walk_node;

      case (state_ff)
         ST_CLEAR: begin
            // every entry points to itself
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = kind_type'(req_kind);
               node_a_in = NODE_W'(req_person_a);
               node_b_in = NODE_W'(req_person_b);
               walk_in   = 2'd0;
               if (in_range) begin
                  state_in = ST_START;
               end else begin
                  // person out of range: table untouched
                  outcome_in = is_set ? OUT_SET_REJECTED : OUT_QUERY_NO;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_START: begin
            // issue first read of this walk
            ram_rd_addr = walk_node;
            root_in     = walk_node;
            state_in    = ST_FIND;
         end
         ST_FIND: begin
            // ram_rd_data is the parent of root_ff
            if (ram_rd_data == root_ff) begin
               roots_in[walk_ff] = root_ff;
               if (walk_node != root_ff) begin
                  ram_rd_addr = walk_node;
                  cur_in      = walk_node;
                  state_in    = ST_COMP;
               end else if (last_walk) begin
                  state_in = ST_DECIDE;
               end else begin
                  walk_in  = walk_ff + 1'b1;
                  state_in = ST_START;
               end
            end else begin
               ram_rd_addr = ram_rd_data;
               root_in     = ram_rd_data;
            end
         end
         ST_COMP: begin
            // repoint cur at the root, read on along the old path
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_ff;
            ram_wr_data = root_ff;
            if (ram_rd_data == root_ff) begin
               if (last_walk) begin
                  state_in = ST_DECIDE;
               end else begin
                  walk_in  = walk_ff + 1'b1;
                  state_in = ST_START;
               end
            end else begin
               ram_rd_addr = ram_rd_data;
               cur_in      = ram_rd_data;
            end
         end
         ST_DECIDE: begin
            if ((kind_ff == KIND_SET_FRIENDS) || (kind_ff == KIND_SET_ENEMIES)) begin
               if (set_reject) begin
                  outcome_in = OUT_SET_REJECTED;
                  state_in   = ST_FINISH;
               end else begin
                  outcome_in = OUT_SET_ACCEPTED;
                  state_in   = ST_UNION1;
               end
            end else begin
               outcome_in = ask_yes ? OUT_QUERY_YES : OUT_QUERY_NO;
               state_in   = ST_FINISH;
            end
         end
         ST_UNION1: begin
            // friends: fa under fb; enemies: ea under fb
            ram_wr_en   = 1'b1;
            ram_wr_addr = (kind_ff == KIND_SET_FRIENDS) ? fa : ea;
            ram_wr_data = fb;
            state_in    = ST_UNION2;
         end
         ST_UNION2: begin
            // friends: ea under eb; enemies: fa under eb
            ram_wr_en   = 1'b1;
            ram_wr_addr = (kind_ff == KIND_SET_FRIENDS) ? ea : fa;
            ram_wr_data = eb;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // hand the outcome over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      root_ff        <= root_in;
      cur_ff         <= cur_in;
      roots_ff       <= roots_in;
      node_a_ff      <= node_a_in;
      node_b_ff      <= node_b_in;
      kind_ff        <= kind_in;
      outcome_ff     <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;

   // no writes while a find walk is in flight
   a_no_write_in_find: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> !ram_wr_en)
      else $error("parent ram written during a find walk");

   // compression never reads the entry it rewrites
   a_comp_addr_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && ram_rd_data != root_ff) |-> (ram_rd_addr != ram_wr_addr))
      else $error("compression read and write hit the same entry");

   // queries hand over a query outcome only
   a_query_outcome: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH
       && (kind_ff == KIND_ASK_FRIENDS || kind_ff == KIND_ASK_ENEMIES))
      |-> (outcome_ff == OUT_QUERY_NO || outcome_ff == OUT_QUERY_YES))
      else $error("query finished with a set outcome");

   // an accepted item leaves the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted twice in a row");

endmodule

`default_nettype wire

### rtl/feuf_ram.sv
// feuf_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies; read returns the old contents on a same-address write
`default_nettype none

module feuf_ram #(
   parameter  int unsigned WIDTH  = 14,
   parameter  int unsigned DEPTH  = 16384,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### test/tb_friend_enemy_union_find_unit.sv
// tb_friend_enemy_union_find_unit: self-checking testbench of the friend/enemy disjoint-set store
// depends on feuf_pkg (kinds, outcome codes, widths) and friend_enemy_union_find_unit
// a directed table, then random requests over small person pools, checked against a local predictor
`timescale 1ns / 1ps

module tb_friend_enemy_union_find_unit;
   import feuf_pkg::*;

   localparam int unsigned NUM_PEOPLE   = PEOPLE_DEFAULT;
   localparam int unsigned NUM_NODES    = 2 * NUM_PEOPLE;
   localparam int unsigned NODE_W       = $clog2(NUM_NODES);
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned PHASE_ITEMS  = 100;
   localparam int unsigned CALM_TAIL    = 150;   // last items run with no idling at all
   localparam int unsigned DRAIN_AT     = 600;   // sender holds off here until all results are in
   localparam int unsigned SETTLE_CYCLES = 40;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // request channel, all driven from time zero
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind     = '0;
   logic [PERSON_W-1:0]   req_person_a = '0;
   logic [PERSON_W-1:0]   req_person_b = '0;

   // result channel
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b1;
   logic [OUTCOME_W-1:0]  rsp_outcome;

   friend_enemy_union_find_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_person_a (req_person_a),
      .req_person_b (req_person_b),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_outcome  (rsp_outcome)
   );

   // ------------------------------------------------------------------
   // predictor: own copy of the parent table
   // ------------------------------------------------------------------
   logic [NODE_W-1:0] parent_copy [0:NUM_NODES-1];

   outcome_type pending_outcomes [$];   // expected outcomes, oldest first
   outcome_type oldest_outcome;
   int unsigned mismatches = 0;

   bit idle_on  = 1'b0;   // sender may leave gaps
   bit stall_on = 1'b0;   // receiver may drop ready
   int unsigned stall_left = 0;

   // root of a node, then point every node on the walked path straight at it
   function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] root;
      logic [NODE_W-1:0] cur;
      logic [NODE_W-1:0] nxt;
      root = node;
      while (parent_copy[root] != root)
         root = parent_copy[root];
      cur = node;
      while (cur != root) begin
         nxt = parent_copy[cur];
         parent_copy[cur] = root;
         cur = nxt;
      end
      return root;
   endfunction

   // outcome of one request, updating the table copy as the block would
   function automatic outcome_type predict_outcome(input kind_type kind,
                                                   input logic [PERSON_W-1:0] a,
                                                   input logic [PERSON_W-1:0] b);
      logic [NODE_W-1:0] fa;
      logic [NODE_W-1:0] fb;
      logic [NODE_W-1:0] ea;
      logic [NODE_W-1:0] eb;
      outcome_type       res;
      // persons past the table are refused without touching it
      if (int'(a) >= NUM_PEOPLE || int'(b) >= NUM_PEOPLE)
         return (kind == KIND_SET_FRIENDS || kind == KIND_SET_ENEMIES) ?
                OUT_SET_REJECTED : OUT_QUERY_NO;
      // same walk order as the block: friend roots first, then enemy roots
      fa = find_root(NODE_W'(a));
      fb = find_root(NODE_W'(b));
      ea = find_root(NODE_W'(a) + NODE_W'(NUM_PEOPLE));
      eb = find_root(NODE_W'(b) + NODE_W'(NUM_PEOPLE));
      case (kind)
         KIND_SET_FRIENDS: begin
            if (fa == eb || ea == fb) begin
               res = OUT_SET_REJECTED;
            end else begin
               parent_copy[fa] = fb;
               parent_copy[ea] = eb;
               res = OUT_SET_ACCEPTED;
            end
         end
         KIND_SET_ENEMIES: begin
            // same person twice lands here as fa == fb and is refused
            if (fa == fb || ea == eb) begin
               res = OUT_SET_REJECTED;
            end else begin
               parent_copy[ea] = fb;
               parent_copy[fa] = eb;
               res = OUT_SET_ACCEPTED;
            end
         end
         KIND_ASK_FRIENDS: res = (fa == fb || ea == eb) ? OUT_QUERY_YES : OUT_QUERY_NO;
         default:          res = (fa == eb || fb == ea) ? OUT_QUERY_YES : OUT_QUERY_NO;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // directed table: typed outcome only where it is plain from the rules
   // ------------------------------------------------------------------
   typedef struct {
      kind_type             kind;
      logic [PERSON_W-1:0]  a;
      logic [PERSON_W-1:0]  b;
      bit                   typed;
      outcome_type          want;
   } probe_row_type;

   localparam int unsigned NUM_PROBES = 21;
   probe_row_type probes [NUM_PROBES] = '{
      // fresh table: everybody is only their own friend
      '{KIND_ASK_FRIENDS, 13'd0,    13'd0,    1'b1, OUT_QUERY_YES},
      '{KIND_ASK_ENEMIES, 13'd0,    13'd0,    1'b1, OUT_QUERY_NO},
      '{KIND_ASK_FRIENDS, 13'd0,    13'd8191, 1'b1, OUT_QUERY_NO},
      '{KIND_ASK_ENEMIES, 13'd8191, 13'd0,    1'b1, OUT_QUERY_NO},
      // same person twice: enemy of oneself refused, friend of oneself a no-op
      '{KIND_SET_ENEMIES, 13'd5,    13'd5,    1'b1, OUT_SET_REJECTED},
      '{KIND_SET_FRIENDS, 13'd5,    13'd5,    1'b1, OUT_SET_ACCEPTED},
      // extremes of the person range made friends, then contradicted
      '{KIND_SET_FRIENDS, 13'd0,    13'd8191, 1'b1, OUT_SET_ACCEPTED},
      '{KIND_ASK_FRIENDS, 13'd8191, 13'd0,    1'b1, OUT_QUERY_YES},
      '{KIND_SET_ENEMIES, 13'd0,    13'd8191, 1'b1, OUT_SET_REJECTED},
      '{KIND_SET_ENEMIES, 13'd1,    13'd8190, 1'b1, OUT_SET_ACCEPTED},
      '{KIND_ASK_ENEMIES, 13'd8190, 13'd1,    1'b1, OUT_QUERY_YES},
      '{KIND_SET_FRIENDS, 13'd1,    13'd8190, 1'b1, OUT_SET_REJECTED},
      '{KIND_SET_ENEMIES, 13'd1,    13'd2,    1'b1, OUT_SET_ACCEPTED},
      // enemy of an enemy and longer chains: left to the predictor
      '{KIND_ASK_FRIENDS, 13'd2,    13'd8190, 1'b0, OUT_QUERY_NO},
      '{KIND_ASK_ENEMIES, 13'd2,    13'd1,    1'b0, OUT_QUERY_NO},
      '{KIND_SET_FRIENDS, 13'd8191, 13'd8190, 1'b0, OUT_QUERY_NO},
      '{KIND_ASK_ENEMIES, 13'd0,    13'd2,    1'b0, OUT_QUERY_NO},
      // mid-range bit patterns on untouched persons
      '{KIND_SET_ENEMIES, 13'd4095, 13'd4096, 1'b1, OUT_SET_ACCEPTED},
      '{KIND_ASK_ENEMIES, 13'd4096, 13'd4095, 1'b1, OUT_QUERY_YES},
      '{KIND_SET_FRIENDS, 13'd6,    13'd7,    1'b1, OUT_SET_ACCEPTED},
      '{KIND_ASK_FRIENDS, 13'd7,    13'd6,    1'b1, OUT_QUERY_YES}
   };

   // ------------------------------------------------------------------
   // sender helpers, all changes at the falling edge
   // ------------------------------------------------------------------

   // present one item and hold it until taken; the predictor runs on acceptance
   task automatic send_request(input kind_type kind, input logic [PERSON_W-1:0] a,
                               input logic [PERSON_W-1:0] b, input bit typed,
                               input outcome_type want);
      outcome_type predicted;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_person_a <= a;
      req_person_b <= b;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = predict_outcome(kind, a, b);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   // drop valid for a number of rising edges
   task automatic idle_sender(input int unsigned cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold off until every outstanding result has come back
   task automatic drain_results();
      idle_sender(1);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // person from the current pool most of the time, anywhere in range otherwise
   function automatic logic [PERSON_W-1:0] pick_person(input int unsigned base,
                                                       input int unsigned span);
      if ($urandom_range(0, 99) < 15)
         return PERSON_W'($urandom_range(0, NUM_PEOPLE - 1));
      return PERSON_W'(base + $urandom_range(0, span - 1));
   endfunction

   // ------------------------------------------------------------------
   // receiver: random bursts of low ready, decided at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_on && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(1, 12) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // result check at the rising edge: oldest expectation first
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("outcome: expected none, actual %0d", rsp_outcome);
            mismatches++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_outcome !== oldest_outcome) begin
               $error("outcome: expected %0d, actual %0d", oldest_outcome, rsp_outcome);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned item;
      int unsigned span;
      int unsigned base;

      for (int unsigned n = 0; n < NUM_NODES; n++)
         parent_copy[n] = NODE_W'(n);

      // reset once; the block then clears its table with req_ready low
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, receiver always ready
      foreach (probes[i])
         send_request(probes[i].kind, probes[i].a, probes[i].b,
                      probes[i].typed, probes[i].want);
      drain_results();

      // random part in phases, each with its own pool of persons
      span = 4;
      base = 0;
      for (item = 0; item < RANDOM_ITEMS; item++) begin
         if (item % PHASE_ITEMS == 0) begin
            case ((item / PHASE_ITEMS) % 4)
               0:       span = 4;
               1:       span = 16;
               2:       span = 32;
               default: span = 256;
            endcase
            // first pool sits at the bottom of the range, last one at the top
            if (item == 0)
               base = 0;
            else if (item + PHASE_ITEMS >= RANDOM_ITEMS)
               base = NUM_PEOPLE - span;
            else
               base = $urandom_range(0, NUM_PEOPLE - span);
            // every third phase and the tail run with no gaps on either side
            idle_on  = ((item / PHASE_ITEMS) % 3 != 2) && (item < RANDOM_ITEMS - CALM_TAIL);
            stall_on = idle_on;
         end
         if (item == DRAIN_AT)
            drain_results();
         if (item + CALM_TAIL >= RANDOM_ITEMS) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         if (idle_on && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 12));
         send_request(kind_type'($urandom_range(0, 3)), pick_person(base, span),
                      pick_person(base, span), 1'b0, OUT_QUERY_NO);
      end

      // wind down: all results in, then a short settle for strays
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("outcome: expected %0d more, actual none", pending_outcomes.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("friend_enemy_union_find_unit: match");
      end else begin
         $display("friend_enemy_union_find_unit: mismatch");
      end
      $finish;
   end

   // watchdog: far beyond the clearing pass plus the slowest plausible run
   initial begin
      #10_000_000;
      $display("friend_enemy_union_find_unit: mismatch");
      $finish;
   end

endmodule
